/* design/frsqrt_pkg.sv */
// ----------------------------------------------------------------------------
// frsqrt_pkg
// Types and single-precision arithmetic steps of the reciprocal square root.
// ----------------------------------------------------------------------------
`default_nettype none

package frsqrt_pkg;

  localparam logic [31:0] MAGIC     = 32'h5f3759df;
  localparam logic [31:0] F_HALF    = 32'h3f000000;
  localparam logic [31:0] F_THREE_H = 32'h3fc00000;
  localparam logic [31:0] CANON_NAN = 32'h7fc00000;
  localparam logic [30:0] INF_MAG   = 31'h7f800000;

  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               zero;
    logic               sign;
    logic signed [10:0] esum;
    logic [47:0]        prod;
  } mul_a_t;

  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               zero;
    logic               sign;
    logic signed [10:0] expo;
    logic [47:0]        norm;
  } mul_b_t;

  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        sign;
    logic        zsign;
    logic [8:0]  expo;
    logic [27:0] sum;
  } add_a_t;

  function automatic logic [5:0] lzc48(logic [47:0] v);
    logic [5:0] n;
    logic       hit;
    n   = 6'd48;
    hit = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 6'(47 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc27(logic [26:0] v);
    logic [4:0] n;
    logic       hit;
    n   = 5'd27;
    hit = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 5'(26 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic mul_a_t fmul_a(logic [31:0] a, logic [31:0] b);
    mul_a_t     r;
    logic       a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
    logic [23:0] ma, mb;
    logic [9:0] ea, eb;
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
    ea     = (a[30:23] == 8'd0) ? 10'd1 : {2'b00, a[30:23]};
    eb     = (b[30:23] == 8'd0) ? 10'd1 : {2'b00, b[30:23]};
    r.nan  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    r.inf  = a_inf | b_inf;
    r.zero = a_zero | b_zero;
    r.sign = a[31] ^ b[31];
    r.esum = signed'({1'b0, ea + eb});
    r.prod = ma * mb;
    return r;
  endfunction

  function automatic mul_b_t fmul_b(mul_a_t a);
    mul_b_t     r;
    logic [5:0] lz;
    lz     = lzc48(a.prod);
    r.nan  = a.nan;
    r.inf  = a.inf;
    r.zero = a.zero | (a.prod == 48'd0);
    r.sign = a.sign;
    r.expo = a.esum - 11'sd126 - signed'({5'd0, lz});
    r.norm = a.prod << lz;
    return r;
  endfunction

  function automatic logic [31:0] fmul_c(mul_b_t a);
    logic [31:0]        res;
    logic signed [10:0] d;
    logic [5:0]         dsh;
    logic [95:0]        sh;
    logic [23:0]        m;
    logic               rnd;
    logic [7:0]         ef;
    d   = 11'sd1 - a.expo;
    dsh = (a.expo >= 11'sd1) ? 6'd0 : ((d > 11'sd63) ? 6'd63 : d[5:0]);
    sh  = {a.norm, 48'd0} >> dsh;
    m   = sh[95:72];
    rnd = sh[71] & ((|sh[70:0]) | m[0]);
    ef  = (a.expo >= 11'sd1) ? a.expo[7:0] : 8'd0;
    if (a.nan) begin
      res = CANON_NAN;
    end else if (a.inf || a.expo >= 11'sd255) begin
      res = {a.sign, INF_MAG};
    end else if (a.zero) begin
      res = {a.sign, 31'd0};
    end else begin
      res = {a.sign, {ef, m[22:0]} + {30'd0, rnd}};
    end
    return res;
  endfunction

  function automatic add_a_t fadd_a(logic [31:0] a, logic [31:0] b);
    add_a_t      r;
    logic        a_inf, b_inf, a_nan, b_nan, swap;
    logic [31:0] big, sml;
    logic [23:0] mbig, msml;
    logic [7:0]  ebig, esml, diff;
    logic [4:0]  dsh;
    logic [55:0] t;
    logic [26:0] av, bv;
    a_inf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    a_nan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    swap   = b[30:0] > a[30:0];
    big    = swap ? b : a;
    sml    = swap ? a : b;
    mbig   = {big[30:23] != 8'd0, big[22:0]};
    msml   = {sml[30:23] != 8'd0, sml[22:0]};
    ebig   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    esml   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    diff   = ebig - esml;
    dsh    = (diff > 8'd31) ? 5'd31 : diff[4:0];
    t      = {msml, 32'd0} >> dsh;
    av     = {mbig, 3'd0};
    bv     = {t[55:30], |t[29:0]};
    r.nan  = a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
    r.inf  = a_inf | b_inf;
    r.sign = big[31];
    r.zsign = a[31] & b[31];
    r.expo = {1'b0, ebig};
    r.sum  = (a[31] != b[31]) ? ({1'b0, av} - {1'b0, bv}) : ({1'b0, av} + {1'b0, bv});
    return r;
  endfunction

  function automatic logic [31:0] fadd_b(add_a_t a);
    logic [31:0] res;
    logic [26:0] m;
    logic [8:0]  e;
    logic [4:0]  lz;
    logic [8:0]  sh;
    logic        rnd;
    logic [7:0]  ef;
    lz = lzc27(a.sum[26:0]);
    if (a.sum[27]) begin
      m = {a.sum[27:2], a.sum[1] | a.sum[0]};
      e = a.expo + 9'd1;
    end else begin
      sh = ({4'd0, lz} > (a.expo - 9'd1)) ? (a.expo - 9'd1) : {4'd0, lz};
      m  = a.sum[26:0] << sh;
      e  = a.expo - sh;
    end
    rnd = m[2] & (m[1] | m[0] | m[3]);
    ef  = m[26] ? e[7:0] : 8'd0;
    if (a.nan) begin
      res = CANON_NAN;
    end else if (a.inf) begin
      res = {a.sign, INF_MAG};
    end else if (a.sum == 28'd0) begin
      res = {a.zsign, 31'd0};
    end else if (e >= 9'd255) begin
      res = {a.sign, INF_MAG};
    end else begin
      res = {a.sign, {ef, m[25:3]} + {30'd0, rnd}};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* design/frsqrt_in_if.sv */
// ----------------------------------------------------------------------------
// frsqrt_in_if
// Input channel: one single-precision pattern per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface frsqrt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] operand_bits;
  modport source (output valid, output operand_bits, input ready);
  modport sink (input valid, input operand_bits, output ready);
endinterface

`default_nettype wire

/* design/frsqrt_out_if.sv */
// ----------------------------------------------------------------------------
// frsqrt_out_if
// Result channel: one single-precision pattern per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface frsqrt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] recip_sqrt_bits;
  modport source (output valid, output recip_sqrt_bits, input ready);
  modport sink (input valid, input recip_sqrt_bits, output ready);
endinterface

`default_nettype wire

/* design/fast_inverse_square_root.sv */
// ----------------------------------------------------------------------------
// fast_inverse_square_root
// Throughput one item per cycle unless stalled, set by the multiplier
// and adder pipeline (three stages per multiply, two for the subtract).
// The whole pipeline holds while the result is not taken.
// Synchronous reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module fast_inverse_square_root (
  input  wire          clk,
  input  wire          rst,
  frsqrt_in_if.sink    operand,
  frsqrt_out_if.source result
);

  localparam int Stages = 14;

  logic [Stages-1:0] vld;
  logic              en;

  frsqrt_pkg::mul_a_t ma1, ma2, ma3, ma4;
  frsqrt_pkg::mul_b_t mb1, mb2, mb3, mb4;
  frsqrt_pkg::add_a_t aa;
  logic [31:0] y1, y2, y3, y4, y5, y6, y7, y8, y9, y10, y11;
  logic [31:0] half, p1, p2, corr, res;

  assign en                     = !vld[Stages-1] || result.ready;
  assign operand.ready          = en && !rst;
  assign result.valid           = vld[Stages-1];
  assign result.recip_sqrt_bits = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Stages-2:0], operand.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma1  <= frsqrt_pkg::fmul_a(operand.operand_bits, frsqrt_pkg::F_HALF);
      y1   <= frsqrt_pkg::MAGIC - {operand.operand_bits[31], operand.operand_bits[31:1]};
      mb1  <= frsqrt_pkg::fmul_b(ma1);
      y2   <= y1;
      half <= frsqrt_pkg::fmul_c(mb1);
      y3   <= y2;
      ma2  <= frsqrt_pkg::fmul_a(half, y3);
      y4   <= y3;
      mb2  <= frsqrt_pkg::fmul_b(ma2);
      y5   <= y4;
      p1   <= frsqrt_pkg::fmul_c(mb2);
      y6   <= y5;
      ma3  <= frsqrt_pkg::fmul_a(p1, y6);
      y7   <= y6;
      mb3  <= frsqrt_pkg::fmul_b(ma3);
      y8   <= y7;
      p2   <= frsqrt_pkg::fmul_c(mb3);
      y9   <= y8;
      aa   <= frsqrt_pkg::fadd_a(frsqrt_pkg::F_THREE_H, {~p2[31], p2[30:0]});
      y10  <= y9;
      corr <= frsqrt_pkg::fadd_b(aa);
      y11  <= y10;
      ma4  <= frsqrt_pkg::fmul_a(y11, corr);
      mb4  <= frsqrt_pkg::fmul_b(ma4);
      res  <= frsqrt_pkg::fmul_c(mb4);
    end
  end

endmodule

`default_nettype wire
